@@ hdl/dfir_pkg.sv @@
// ----------------------------------------------------------------------------
// Decimating FIR package
// Field widths, register and opcode codes, and the per-cell control group.
// ----------------------------------------------------------------------------
package dfir_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TAP_IDX_W = 5;
  localparam int DEC_W     = 7;
  localparam int PHASE_W   = 6;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int CFG_IDX_W = 1;
  localparam int MAX_DEC   = 64;

  // Input item opcodes.
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_LOAD_TAP = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_STATE = 1'b1;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctrl_t;

endpackage

@@ hdl/dfir_if.sv @@
// ----------------------------------------------------------------------------
// Decimating FIR channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface dfir_in_if;
  import dfir_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic signed [SAMPLE_W-1:0]  sample;
  logic [TAP_IDX_W-1:0]        tap_index;
  logic signed [SAMPLE_W-1:0]  tap_value;
  logic                        last_in_block;

  modport source (output valid, opcode, sample, tap_index, tap_value, last_in_block,
                  input ready);
  modport sink   (input valid, opcode, sample, tap_index, tap_value, last_in_block,
                  output ready);
endinterface

interface dfir_out_if;
  import dfir_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  filtered;
  logic                        clipped;

  modport source (output valid, filtered, clipped, input ready);
  modport sink   (input valid, filtered, clipped, output ready);
endinterface

interface dfir_cfg_if;
  import dfir_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [DEC_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/decimating_fir_filter.sv @@
// A sample or coefficient item is stored as it is accepted; a sample that is due
// for an output gives its result once its sum has walked the cell chain.
// Throughput: one item per cycle, except that an output-due sample holds the
// input while it waits for a free output register and while its sum walks the
// cell chain, one cell a cycle. Reset clears the delay line, the phase and the
// registers (decimation 1, save on); coefficients are undefined until loaded.
// ----------------------------------------------------------------------------
// Decimating FIR filter
// Q1.15 FIR with decimation, built as a chain of multiply-accumulate cells.
// ----------------------------------------------------------------------------
module decimating_fir_filter #(
  parameter int TAPS = 32
) (
  input  logic        clk,
  input  logic        rst,
  dfir_in_if.sink     samples,
  dfir_out_if.source  results,
  dfir_cfg_if.sink    cfg
);
  import dfir_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
  localparam int QW    = ACC_W - 15;
  localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN = QW'(-32768);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WAIT = 3'b010,
    ST_SUM  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [DEC_W-1:0]           decimation;
  logic                       save_state;
  logic [PHASE_W-1:0]         phase;
  logic                       clr_pending;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_filtered;
  logic                       out_clipped;

  logic                       accept;
  logic                       accept_sample;
  logic                       accept_load;
  logic                       due;
  logic                       block_clear;
  logic                       start;
  logic [DEC_W-1:0]           dec_eff;
  cell_ctrl_t                 ctrl;

  logic signed [SAMPLE_W-1:0] line [TAPS];
  logic signed [ACC_W-1:0]    sum  [TAPS+1];
  logic                       go   [TAPS+1];

  logic signed [ACC_W-1:0]    rnd;
  logic signed [QW-1:0]       q;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic                       sat_clip;

  // Handshakes.
  assign samples.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign accept        = samples.valid && samples.ready;
  assign accept_sample = accept && (samples.opcode == OP_SAMPLE);
  assign accept_load   = accept && (samples.opcode == OP_LOAD_TAP);
  assign due           = (phase == '0);
  assign block_clear   = accept_sample && samples.last_in_block && !save_state;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      decimation <= DEC_W'(1);
      save_state <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_DECIMATION: decimation <= cfg.data;
        CFG_SAVE_STATE: save_state <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Effective decimation, clamped to 1..64.
  always_comb begin
    if (decimation == '0) begin
      dec_eff = DEC_W'(1);
    end else if (decimation > DEC_W'(MAX_DEC)) begin
      dec_eff = DEC_W'(MAX_DEC);
    end else begin
      dec_eff = decimation;
    end
  end

  // Phase countdown.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept_sample) begin
      if (block_clear) begin
        phase <= '0;
      end else if (due) begin
        phase <= PHASE_W'(dec_eff - DEC_W'(1));
      end else begin
        phase <= phase - PHASE_W'(1);
      end
    end
  end

  // Sequencer: wait for a free output register, then run the sum down the chain.
  assign start = (state == ST_WAIT) && !out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept_sample && due) state_next = ST_WAIT;
      ST_WAIT: if (!out_valid)           state_next = ST_SUM;
      ST_SUM:  if (go[TAPS])             state_next = ST_IDLE;
      default:                           state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A block-end clear on a sample due for an output waits until the window has been summed.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_pending <= 1'b0;
    end else if (block_clear && due) begin
      clr_pending <= 1'b1;
    end else if (go[TAPS]) begin
      clr_pending <= 1'b0;
    end
  end

  assign ctrl.shift = accept_sample;
  assign ctrl.clr   = (block_clear && !due) || (go[TAPS] && clr_pending);

  // Cell chain: cell k holds the sample k steps back and coefficient TAPS-1-k.
  assign sum[0] = '0;
  assign go[0]  = start;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    localparam int CI = TAPS - 1 - k;
    logic                       we;
    logic signed [SAMPLE_W-1:0] s_in;

    assign we   = accept_load && (CI < (1 << TAP_IDX_W))
                  && (samples.tap_index == TAP_IDX_W'(CI));
    assign s_in = (k == 0) ? samples.sample : line[(k == 0) ? 0 : k - 1];

    dfir_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .coef_we    (we),
      .coef_in    (samples.tap_value),
      .sample_in  (s_in),
      .sample_out (line[k]),
      .sum_in     (sum[k]),
      .go_in      (go[k]),
      .sum_out    (sum[k+1]),
      .go_out     (go[k+1])
    );
  end

  // Round half up to Q1.15 and saturate.
  assign rnd = sum[TAPS] + ACC_W'(16384);
  assign q   = QW'(rnd >>> 15);

  always_comb begin
    if (q > Q_MAX) begin
      sat_val  = 16'sh7FFF;
      sat_clip = 1'b1;
    end else if (q < Q_MIN) begin
      sat_val  = -16'sh8000;
      sat_clip = 1'b1;
    end else begin
      sat_val  = SAMPLE_W'(q);
      sat_clip = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go[TAPS]) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go[TAPS]) begin
      out_filtered <= sat_val;
      out_clipped  <= sat_clip;
    end
  end

  assign results.valid    = out_valid;
  assign results.filtered = out_filtered;
  assign results.clipped  = out_clipped;

  // The sum only finishes while summing, and then into an empty output register.
  a_done_in_sum: assert property (@(posedge clk) disable iff (rst)
    go[TAPS] |-> (state == ST_SUM) && !out_valid)
    else $error("sum finished outside the summing state or over a held result");

  a_done_gives_item: assert property (@(posedge clk) disable iff (rst)
    go[TAPS] |=> out_valid && (state == ST_IDLE))
    else $error("finished sum did not produce an item");

  a_clear_while_busy: assert property (@(posedge clk) disable iff (rst)
    clr_pending |-> (state != ST_IDLE))
    else $error("block-end clear pending while idle");

endmodule

@@ hdl/dfir_cell.sv @@
// ----------------------------------------------------------------------------
// Decimating FIR cell
// Holds one delay-line sample and one coefficient, and adds its product to
// the partial sum as it walks down the chain.
// ----------------------------------------------------------------------------
module dfir_cell #(
  parameter int ACC_W = 38
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dfir_pkg::cell_ctrl_t         ctrl,
  input  logic                         coef_we,
  input  logic signed [dfir_pkg::SAMPLE_W-1:0] coef_in,
  input  logic signed [dfir_pkg::SAMPLE_W-1:0] sample_in,
  output logic signed [dfir_pkg::SAMPLE_W-1:0] sample_out,
  input  logic signed [ACC_W-1:0]      sum_in,
  input  logic                         go_in,
  output logic signed [ACC_W-1:0]      sum_out,
  output logic                         go_out
);
  import dfir_pkg::*;

  logic signed [SAMPLE_W-1:0] line;
  logic signed [SAMPLE_W-1:0] coef;
  logic signed [PROD_W-1:0]   prod;

  assign sample_out = line;
  assign prod       = coef * line;

  // Delay-line tap: a clear wins over a shift on the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      line <= '0;
    end else if (ctrl.clr) begin
      line <= '0;
    end else if (ctrl.shift) begin
      line <= sample_in;
    end
  end

  // Coefficient storage, loaded one entry at a time.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef <= coef_in;
    end
  end

  // Partial sum hop to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      go_out <= 1'b0;
    end else begin
      go_out <= go_in;
    end
  end

  always_ff @(posedge clk) begin
    if (go_in) begin
      sum_out <= sum_in + ACC_W'(prod);
    end
  end

endmodule

@@ dv/tb_decimating_fir_filter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimating FIR filter testbench
// Loads coefficients and walks the filter through several decimation and
// block-save settings. Each output is checked against a behavioral predictor
// of the Q1.15 dot product, rounding, saturation and phase countdown.
// ----------------------------------------------------------------------------
module tb_decimating_fir_filter;
  import dfir_pkg::*;

  localparam int TAPS        = 32;
  localparam int NUM_ITEMS   = 1650;
  localparam int DRAIN_WAIT  = TAPS + 8;
  localparam int STALL_LIMIT = 5000;
  localparam int IDLE_PCT    = 26;
  localparam int MAX_REPORTS = 10;

  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] HALF_POS = 16'sh4000;
  localparam longint SAT_HI = 32767;
  localparam longint SAT_LO = -32768;

  typedef struct packed {
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TAP_IDX_W-1:0]       tap_index;
    logic signed [SAMPLE_W-1:0] tap_value;
    logic                       last_in_block;
  } fir_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } fir_output_t;

  // Predicts the filter outputs and holds the ones still to arrive.
  class fir_output_predictor;
    logic [DEC_W-1:0]           decimation;
    logic                       save_state;
    logic signed [SAMPLE_W-1:0] window [TAPS];
    logic signed [SAMPLE_W-1:0] coeffs [TAPS];
    logic [PHASE_W-1:0]         countdown;
    fir_output_t                due_outputs [$];
    int                         mismatches;

    function new();
      decimation = 7'd1;
      save_state = 1'b1;
      countdown  = '0;
      mismatches = 0;
      foreach (window[k]) window[k] = '0;
      foreach (coeffs[k]) coeffs[k] = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DEC_W-1:0] data);
      if (idx == CFG_DECIMATION) begin
        decimation = data;
      end else begin
        save_state = data[0];
      end
    endfunction

    // Stores a coefficient, or shifts a sample into the window and works out its output when one is due.
    function void accept_item(fir_item_t it);
      int          factor;
      longint      acc;
      longint      rounded;
      fir_output_t res;
      if (it.opcode == OP_LOAD_TAP) begin
        coeffs[it.tap_index] = it.tap_value;
        return;
      end
      factor = int'(decimation);
      if (factor < 1) factor = 1;
      if (factor > MAX_DEC) factor = MAX_DEC;
      for (int k = TAPS - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = it.sample;
      if (countdown == '0) begin
        acc = 0;
        for (int i = 0; i < TAPS; i++) begin
          acc += longint'(coeffs[i]) * longint'(window[TAPS - 1 - i]);
        end
        // Round half toward plus infinity, then saturate to Q1.15.
        rounded = (acc + 64'sd16384) >>> 15;
        res.clipped = 1'b0;
        if (rounded > SAT_HI) begin
          rounded = SAT_HI;
          res.clipped = 1'b1;
        end else if (rounded < SAT_LO) begin
          rounded = SAT_LO;
          res.clipped = 1'b1;
        end
        res.filtered = rounded[SAMPLE_W-1:0];
        due_outputs.push_back(res);
        countdown = PHASE_W'(factor - 1);
      end else begin
        countdown = countdown - 1'b1;
      end
      // In no-save mode a block end wipes the history and the phase.
      if (it.last_in_block && !save_state) begin
        foreach (window[k]) window[k] = '0;
        countdown = '0;
      end
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] filtered, logic clipped);
      fir_output_t want;
      if (due_outputs.size() == 0) begin
        note_mismatch($sformatf("output with none expected: filtered %0d clipped %0b",
                                filtered, clipped));
        return;
      end
      want = due_outputs.pop_front();
      if (filtered !== want.filtered || clipped !== want.clipped) begin
        note_mismatch($sformatf("filtered expected %0d got %0d, clipped expected %0b got %0b",
                                want.filtered, filtered, want.clipped, clipped));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic no_idle;
  int   items_sent;
  int   quiet_cycles;

  fir_output_predictor filter_model = new();

  dfir_in_if  sample_ch ();
  dfir_out_if result_ch ();
  dfir_cfg_if cfg_ch ();

  decimating_fir_filter #(
    .TAPS(TAPS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  // Clock generation.
  always #4 clk = ~clk;

  // The result side stalls at random except during the no-idle stretch.
  always @(negedge clk) begin
    result_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      filter_model.check_output(result_ch.filtered, result_ch.clipped);
    end
  end

  // Watchdog on cycles where no channel moves anything.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_decimating_fir_filter NOT OK");
        $finish;
      end
    end
  end

  function automatic fir_item_t make_sample(logic signed [SAMPLE_W-1:0] value,
                                            logic ends_block);
    fir_item_t it;
    it.opcode        = OP_SAMPLE;
    it.sample        = value;
    it.tap_index     = TAP_IDX_W'($urandom);
    it.tap_value     = SAMPLE_W'($urandom);
    it.last_in_block = ends_block;
    return it;
  endfunction

  function automatic fir_item_t make_load(logic [TAP_IDX_W-1:0] idx,
                                          logic signed [SAMPLE_W-1:0] value);
    fir_item_t it;
    it.opcode        = OP_LOAD_TAP;
    it.sample        = SAMPLE_W'($urandom);
    it.tap_index     = idx;
    it.tap_value     = value;
    it.last_in_block = 1'($urandom);
    return it;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_tap(logic wide);
    if (wide) return SAMPLE_W'($urandom);
    return SAMPLE_W'($urandom_range(0, 4095) - 2048);
  endfunction

  // Offers one item after a random gap and waits for it to be taken.
  task automatic send_item(fir_item_t it);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.opcode        <= it.opcode;
    sample_ch.sample        <= it.sample;
    sample_ch.tap_index     <= it.tap_index;
    sample_ch.tap_value     <= it.tap_value;
    sample_ch.last_in_block <= it.last_in_block;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    filter_model.accept_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Stops sending until every predicted output is in, then waits a bit more.
  task automatic hold_until_drained(int extra);
    sample_ch.valid <= 1'b0;
    do @(negedge clk); while (filter_model.due_outputs.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DEC_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    filter_model.set_register(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int               phase_no;
    int               phase_len;
    int               pause_at;
    logic [DEC_W-1:0] dec_val;
    logic [DEC_W-1:0] save_val;
    logic             wide_taps;
    logic signed [SAMPLE_W-1:0] value;

    clk                     = 1'b0;
    rst                     = 1'b1;
    no_idle                 = 1'b0;
    items_sent              = 0;
    quiet_cycles            = 0;
    sample_ch.valid         = 1'b0;
    sample_ch.opcode        = OP_SAMPLE;
    sample_ch.sample        = '0;
    sample_ch.tap_index     = '0;
    sample_ch.tap_value     = '0;
    sample_ch.last_in_block = 1'b0;
    result_ch.ready         = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = CFG_DECIMATION;
    cfg_ch.data             = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every coefficient is written before the first output falls due.
    for (int i = 0; i < TAPS; i++) send_item(make_load(TAP_IDX_W'(i), FULL_NEG));

    // Full-scale products push the sum past the positive limit.
    send_item(make_sample(FULL_NEG, 1'b0));
    send_item(make_sample(FULL_NEG, 1'b0));
    send_item(make_sample(FULL_POS, 1'b0));
    // With history kept, a block end changes nothing.
    send_item(make_sample('0, 1'b1));
    // Coefficient loads at both ends of the index range.
    send_item(make_load('0, FULL_POS));
    send_item(make_load('1, FULL_POS));
    send_item(make_sample(FULL_POS, 1'b0));
    send_item(make_sample(16'sd1, 1'b1));

    hold_until_drained(DRAIN_WAIT);
    write_reg(CFG_SAVE_STATE, 7'd0);
    // Each block end clears the history, so after the first one the newest tap alone sets the output.
    send_item(make_sample(FULL_NEG, 1'b1));
    send_item(make_load('1, HALF_POS));
    send_item(make_sample(16'sd1, 1'b1));
    send_item(make_sample(-16'sd1, 1'b1));
    send_item(make_sample(16'sd3, 1'b1));
    // Positive samples against mostly negative taps pass the lower limit.
    repeat (3) send_item(make_sample(FULL_POS, 1'b0));

    hold_until_drained(DRAIN_WAIT);
    write_reg(CFG_DECIMATION, 7'd3);
    // A block end in mid-count restarts the phase on the next sample.
    send_item(make_sample(16'sd100, 1'b0));
    send_item(make_sample(16'sd200, 1'b1));
    send_item(make_sample(16'sd300, 1'b0));
    send_item(make_sample(16'sd400, 1'b0));

    // A factor of zero acts as one, and one above the maximum as the maximum.
    hold_until_drained(DRAIN_WAIT);
    write_reg(CFG_DECIMATION, 7'd0);
    repeat (2) send_item(make_sample(16'sd500, 1'b0));
    hold_until_drained(DRAIN_WAIT);
    write_reg(CFG_DECIMATION, 7'd127);
    repeat (2) send_item(make_sample(-16'sd500, 1'b0));

    // Random phases, each with its own register settings.
    phase_no = 0;
    while (items_sent < NUM_ITEMS) begin
      hold_until_drained(DRAIN_WAIT);
      case ($urandom_range(0, 7))
        0:       dec_val = 7'd1;
        1:       dec_val = 7'd2;
        2:       dec_val = 7'(MAX_DEC);
        3:       dec_val = 7'd0;
        4:       dec_val = 7'($urandom_range(MAX_DEC + 1, 127));
        default: dec_val = 7'($urandom_range(1, MAX_DEC));
      endcase
      save_val = DEC_W'($urandom);
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_DECIMATION, dec_val);
        write_reg(CFG_SAVE_STATE, save_val);
      end else begin
        write_reg(CFG_SAVE_STATE, save_val);
        write_reg(CFG_DECIMATION, dec_val);
      end

      // Wide taps clip often; narrow ones keep most outputs in range.
      wide_taps = 1'($urandom);
      if ($urandom_range(0, 1)) begin
        for (int i = 0; i < TAPS; i++) send_item(make_load(TAP_IDX_W'(i), pick_tap(wide_taps)));
      end

      no_idle   = (phase_no == 3);
      phase_len = $urandom_range(60, 160);
      pause_at  = (phase_no == 1 || $urandom_range(0, 3) == 0) ?
                  $urandom_range(1, phase_len - 1) : -1;
      for (int n = 0; n < phase_len; n++) begin
        if (n == pause_at) hold_until_drained(0);
        if ($urandom_range(0, 99) < 6) begin
          send_item(make_load(TAP_IDX_W'($urandom), pick_tap(wide_taps)));
        end else begin
          case ($urandom_range(0, 9)) inside
            0:       value = FULL_NEG;
            1:       value = FULL_POS;
            [2:3]:   value = SAMPLE_W'($urandom_range(0, 1023) - 512);
            default: value = SAMPLE_W'($urandom);
          endcase
          send_item(make_sample(value, $urandom_range(0, 99) < 5));
        end
      end
      no_idle = 1'b0;
      phase_no++;
    end

    hold_until_drained(DRAIN_WAIT);
    if (filter_model.mismatches == 0 && filter_model.due_outputs.size() == 0) begin
      $display("tb_decimating_fir_filter OK");
    end else begin
      $display("tb_decimating_fir_filter NOT OK");
    end
    $finish;
  end

endmodule
